// File: rtl/port_change_events_quadrature_defines.svh
// Assertion macros used by the port change event RTL.
// Included by pceq_back, the module that carries concurrent checks; no other dependencies.
`ifndef PORT_CHANGE_EVENTS_QUADRATURE_DEFINES_SVH
`define PORT_CHANGE_EVENTS_QUADRATURE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication or plain property, disabled while in reset
`define PCEQ_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pceq check failed");
// Condition that must never be seen
`define PCEQ_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("pceq forbidden condition");
`else
`define PCEQ_ASSERT(name, clk, rst, prop)
`define PCEQ_NEVER(name, clk, rst, cond)
`endif

`endif

// File: rtl/pceq_pkg.sv
// Shared constants for the port change event detector with quadrature decode.
// No dependencies; imported by every module of the block.
package pceq_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_ROT_A      = 2'd0;
  localparam logic [1:0] REG_ROT_B      = 2'd1;
  localparam logic [1:0] REG_STEP_TABLE = 2'd2;

  // Register reset values
  localparam logic [3:0]  ROT_A_RESET      = 4'd0;
  localparam logic [3:0]  ROT_B_RESET      = 4'd1;
  localparam logic [31:0] STEP_TABLE_RESET = 32'h3443_C11C;

  // Event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ROTARY  = 2'd2;

  // Queue between the classifier and the event serializer
  localparam int QUEUE_DEPTH = 4;

endpackage

// File: rtl/pceq_front.sv
// Front end: holds configuration, compares each sample with the previous one,
// decodes the encoder pair and hands a classified entry to the queue. Uses pceq_pkg.
module pceq_front #(
  parameter int PORT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PORT_WIDTH-1:0] in_sample,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic                  push_rot,
  output logic [1:0]            push_step,
  output logic [PORT_WIDTH-1:0] push_mask,
  output logic [PORT_WIDTH-1:0] push_cur
);
  import pceq_pkg::*;

  logic [3:0]            rotary_a_bit;
  logic [3:0]            rotary_b_bit;
  logic [31:0]           step_table;
  logic [PORT_WIDTH-1:0] previous_sample;
  logic [1:0]            last_ab_pair;

  logic                  accept;
  logic [PORT_WIDTH-1:0] changed;
  logic                  a_in, b_in;
  logic [PORT_WIDTH-1:0] rmask;
  logic                  a_lvl, b_lvl;
  logic                  rot_hit;
  logic [3:0]            tab_idx;
  logic [1:0]            step_sel;
  logic                  rot_emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;

  // Encoder bits outside the port read as inactive and never change
  assign a_in  = {28'd0, rotary_a_bit} < 32'(PORT_WIDTH);
  assign b_in  = {28'd0, rotary_b_bit} < 32'(PORT_WIDTH);
  assign rmask = (a_in ? (PORT_WIDTH'(1) << rotary_a_bit) : '0)
               | (b_in ? (PORT_WIDTH'(1) << rotary_b_bit) : '0);
  assign a_lvl = a_in ? (PORT_WIDTH'(in_sample >> rotary_a_bit) & PORT_WIDTH'(1)) != '0
                      : 1'b1;
  assign b_lvl = b_in ? (PORT_WIDTH'(in_sample >> rotary_b_bit) & PORT_WIDTH'(1)) != '0
                      : 1'b1;

  // Change detection and step lookup
  assign changed  = in_sample ^ previous_sample;
  assign rot_hit  = (changed & rmask) != '0;
  assign tab_idx  = {last_ab_pair, ~a_lvl, ~b_lvl};
  assign step_sel = 2'(step_table >> {tab_idx, 1'b0});
  assign rot_emit = rot_hit && (step_sel != 2'd0) && (rotary_a_bit != rotary_b_bit);

  assign push_rot   = rot_emit;
  assign push_step  = step_sel;
  assign push_mask  = changed & ~rmask;
  assign push_cur   = in_sample;
  // Samples that cause no event are absorbed here
  assign push_valid = in_valid && (rot_emit || (push_mask != '0));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotary_a_bit <= ROT_A_RESET;
      rotary_b_bit <= ROT_B_RESET;
      step_table   <= STEP_TABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROT_A:      rotary_a_bit <= cfg_data[3:0];
        REG_ROT_B:      rotary_b_bit <= cfg_data[3:0];
        REG_STEP_TABLE: step_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sample history and encoder pair
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '1;
      last_ab_pair    <= 2'b00;
    end else if (accept) begin
      previous_sample <= in_sample;
      if (rot_hit) begin
        last_ab_pair <= {~a_lvl, ~b_lvl};
      end
    end
  end

endmodule

// File: rtl/pceq_queue.sv
// Small FIFO of classified entries between the front end and the serializer.
// Depth from pceq_pkg; entry width from the parameter.
module pceq_queue #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import pceq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CW'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_data  = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= PW'((32'(wptr) + 1) % QUEUE_DEPTH);
      if (pop)  rptr <= PW'((32'(rptr) + 1) % QUEUE_DEPTH);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/pceq_back.sv
// Back end: takes one entry at a time and emits its events, one beat per cycle while
// out_ready holds, rotary step first, then changed bits lowest first. Uses pceq_pkg and the defines.
`include "port_change_events_quadrature_defines.svh"
module pceq_back #(
  parameter int PORT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic                  q_rot,
  input  logic [1:0]            q_step,
  input  logic [PORT_WIDTH-1:0] q_mask,
  input  logic [PORT_WIDTH-1:0] q_cur,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_index,
  output logic [1:0]            out_step,
  output logic                  out_last
);
  import pceq_pkg::*;

  logic                  busy;
  logic                  rot_pend;
  logic [1:0]            step;
  logic [PORT_WIDTH-1:0] mask;
  logic [PORT_WIDTH-1:0] cur;

  logic                  load;
  logic                  advance;
  logic [PORT_WIDTH-1:0] low;
  logic [PORT_WIDTH-1:0] mask_rest;
  logic [3:0]            low_index;
  logic                  low_level;
  logic                  emit_last;

  assign q_ready = !busy;
  assign load    = q_valid && !busy;
  assign advance = busy && (!out_valid || out_ready);

  // Lowest pending bit and its position
  assign low       = mask & (~mask + PORT_WIDTH'(1));
  assign mask_rest = mask & ~low;
  assign low_level = (low & cur) != '0;
  always_comb begin
    low_index = 4'd0;
    for (int i = 0; i < PORT_WIDTH; i++) begin
      if (low[i]) low_index = low_index | 4'(i);
    end
  end
  assign emit_last = rot_pend ? (mask == '0) : (mask_rest == '0);

  // Working entry
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rot_pend <= 1'b0;
    end else if (load) begin
      busy     <= 1'b1;
      rot_pend <= q_rot;
    end else if (advance) begin
      rot_pend <= 1'b0;
      if (emit_last) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step <= q_step;
      mask <= q_mask;
      cur  <= q_cur;
    end else if (advance && !rot_pend) begin
      mask <= mask_rest;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last <= emit_last;
      if (rot_pend) begin
        out_kind  <= KIND_ROTARY;
        out_index <= 4'd0;
        out_step  <= step;
      end else begin
        out_kind  <= low_level ? KIND_RELEASE : KIND_PRESS;
        out_index <= low_index;
        out_step  <= 2'd0;
      end
    end
  end

  // A bit-only entry in progress always has a bit left to send
  `PCEQ_ASSERT(a_bits_left, clk, rst, busy && !rot_pend |-> mask != '0)
  // The final beat of an entry frees the serializer
  `PCEQ_ASSERT(a_last_frees, clk, rst, advance && emit_last |=> !busy)
  // Only entries with at least one event are taken
  `PCEQ_NEVER(a_empty_load, clk, rst, load && !q_rot && q_mask == '0)

endmodule

// File: rtl/port_change_events_quadrature.sv
// Port change event detector with quadrature decode. The first event beat of a sample
// passes through the queue, the serializer's working entry and its output register.
// A sample with k events is loaded into the serializer, which then emits k beats,
// one beat per cycle without output stalls. Samples with no event are taken while
// the 4-entry queue has room; the queue decouples the sides.
// Reset (rst, synchronous): previous sample all ones, encoder pair zero, default registers.
module port_change_events_quadrature #(
  parameter int PORT_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // port_sample in the low PORT_WIDTH bits, zero padded to bytes
  input  logic [((PORT_WIDTH + 7) / 8) * 8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // event_kind[1:0], bit_index[5:2], step[7:6]
  output logic [7:0]                           m_tdata,
  output logic                                 m_tlast
);
  import pceq_pkg::*;

  localparam int EW = 3 + 2 * PORT_WIDTH;

  logic                  f_valid, f_ready;
  logic                  f_rot;
  logic [1:0]            f_step;
  logic [PORT_WIDTH-1:0] f_mask, f_cur;
  logic                  q_valid, q_ready;
  logic [EW-1:0]         q_data;
  logic [1:0]            o_kind, o_step;
  logic [3:0]            o_index;

  // Classifier
  pceq_front #(.PORT_WIDTH(PORT_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata[PORT_WIDTH-1:0]),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_rot   (f_rot),
    .push_step  (f_step),
    .push_mask  (f_mask),
    .push_cur   (f_cur)
  );

  // Entry queue
  pceq_queue #(.WIDTH(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cur, f_mask, f_step, f_rot}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  // Event serializer
  pceq_back #(.PORT_WIDTH(PORT_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_rot     (q_data[0]),
    .q_step    (q_data[2:1]),
    .q_mask    (q_data[PORT_WIDTH+2:3]),
    .q_cur     (q_data[EW-1:PORT_WIDTH+3]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (o_kind),
    .out_index (o_index),
    .out_step  (o_step),
    .out_last  (m_tlast)
  );

  assign m_tdata = {o_step, o_index, o_kind};

endmodule
